// ----- hw/rtl/otrb_pkg.sv -----
// otrb_pkg: shared types and constants of the overwrite ring trace buffer
// transaction payload structs, operation codes, sequencer states, register map
// no dependencies
package otrb_pkg;

  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned PAYLOAD_W  = 64;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_DEPTH     = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ERR_LEVEL = 1'b1;

  localparam logic [LEVEL_W-1:0] ERR_LEVEL_RST = 3'd3;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_DUMP  = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [LEVEL_W-1:0]   entry_level;
    logic [PAYLOAD_W-1:0] entry_payload;
    logic [LEVEL_W-1:0]   min_level;
    logic [COUNT_W-1:0]   max_count;
  } in_item_t;

  typedef struct packed {
    logic                 out_valid;
    logic [LEVEL_W-1:0]   out_level;
    logic [PAYLOAD_W-1:0] out_payload;
    logic                 last_of_run;
    logic [COUNT_W-1:0]   stored_count;
  } out_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] depth;
    logic [LEVEL_W-1:0] err_level;
    logic               clear;
  } cfg_t;

endpackage

// ----- hw/rtl/otrb_ram.sv -----
// otrb_ram: generic single write port, single read port ram with registered read
// no dependencies
module otrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/otrb_cfg.sv -----
// otrb_cfg: apb register block holding depth in use and error level
// depends on otrb_pkg
module otrb_cfg #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [otrb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [otrb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [otrb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output otrb_pkg::cfg_t                   cfg_o
);

  logic [otrb_pkg::COUNT_W-1:0]   depth_q, depth_d;
  logic [otrb_pkg::LEVEL_W-1:0]   err_q, err_d;
  logic [otrb_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;
  logic                           depth_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[otrb_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    depth_d  = depth_q;
    err_d    = err_q;
    depth_wr = 1'b0;
    if (wr_en) begin
      unique case (reg_idx)
        otrb_pkg::REG_DEPTH: begin
          depth_d  = pwdata[otrb_pkg::COUNT_W-1:0];
          depth_wr = 1'b1;
        end
        otrb_pkg::REG_ERR_LEVEL: begin
          err_d = pwdata[otrb_pkg::LEVEL_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      otrb_pkg::REG_DEPTH:     prdata = otrb_pkg::APB_DATA_W'(depth_q);
      otrb_pkg::REG_ERR_LEVEL: prdata = otrb_pkg::APB_DATA_W'(err_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= otrb_pkg::COUNT_W'(DEPTH);
      err_q   <= otrb_pkg::ERR_LEVEL_RST;
    end else begin
      depth_q <= depth_d;
      err_q   <= err_d;
    end
  end

  // clamp to the usable range
  always_comb begin
    if (depth_q == '0) begin
      cfg_o.depth = otrb_pkg::COUNT_W'(1);
    end else if (depth_q > otrb_pkg::COUNT_W'(DEPTH)) begin
      cfg_o.depth = otrb_pkg::COUNT_W'(DEPTH);
    end else begin
      cfg_o.depth = depth_q;
    end
  end

  assign cfg_o.err_level = err_q;
  assign cfg_o.clear     = depth_wr;

endmodule

// ----- hw/rtl/otrb_ctrl.sv -----
// otrb_ctrl: sequencer walking the ring through one level comparator, plus output register
// depends on otrb_pkg; drives the ports of otrb_ram
module otrb_ctrl #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned PAYLOAD_BITS = 64,
  parameter int unsigned LEVEL_BITS   = 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  otrb_pkg::cfg_t                      cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  otrb_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output otrb_pkg::out_item_t                 out_data_o,
  output logic                                ram_we_o,
  output logic [$clog2(DEPTH)-1:0]            ram_waddr_o,
  output logic [LEVEL_BITS+PAYLOAD_BITS-1:0]  ram_wdata_o,
  output logic                                ram_re_o,
  output logic [$clog2(DEPTH)-1:0]            ram_raddr_o,
  input  logic [LEVEL_BITS+PAYLOAD_BITS-1:0]  ram_rdata_i
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  otrb_pkg::state_e state_q, state_d;

  logic [PTR_W-1:0]                 wp_q, wp_d;
  logic [CNT_W-1:0]                 held_q, held_d;
  logic [PTR_W-1:0]                 idx_q, idx_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [otrb_pkg::COUNT_W-1:0]     n_q, n_d;
  logic [otrb_pkg::COUNT_W-1:0]     max_q, max_d;
  logic [otrb_pkg::LEVEL_W-1:0]     thr_q, thr_d;
  logic                             dump_q, dump_d;
  logic                             pend_v_q, pend_v_d;
  logic [otrb_pkg::LEVEL_W-1:0]     pend_lvl_q, pend_lvl_d;
  logic [otrb_pkg::PAYLOAD_W-1:0]   pend_pay_q, pend_pay_d;
  logic                             out_full_q, out_full_d;
  otrb_pkg::out_item_t              out_q, out_d;

  logic [CNT_W-1:0]                 depth;
  logic [PTR_W-1:0]                 last_ptr;
  logic [LEVEL_BITS-1:0]            rd_level;
  logic [PAYLOAD_BITS-1:0]          rd_pay;
  logic [otrb_pkg::LEVEL_W-1:0]     rd_lvl;
  logic                             match;
  logic                             out_free;
  logic                             accept;
  logic                             last_visit;
  logic                             cap_hit;
  logic                             push_blocked;
  logic [PTR_W-1:0]                 next_idx;
  logic [PTR_W-1:0]                 next_wp;
  otrb_pkg::mode_e                  in_mode;

  assign depth        = CNT_W'(cfg_i.depth);
  assign last_ptr     = PTR_W'(depth - CNT_W'(1));
  assign rd_level     = ram_rdata_i[PAYLOAD_BITS +: LEVEL_BITS];
  assign rd_pay       = ram_rdata_i[PAYLOAD_BITS-1:0];
  assign rd_lvl       = otrb_pkg::LEVEL_W'(rd_level);
  // the one shared comparator
  assign match        = rd_lvl >= thr_q;
  assign out_free     = !out_full_q || out_ready_i;
  assign in_ready_o   = (state_q == otrb_pkg::ST_IDLE);
  assign accept       = in_valid_i && in_ready_o;
  assign in_mode      = otrb_pkg::mode_e'(in_data_i.mode);
  assign last_visit   = (cnt_q + CNT_W'(1)) == held_q;
  assign cap_hit      = dump_q && match && ((n_q + otrb_pkg::COUNT_W'(1)) == max_q);
  assign push_blocked = dump_q && match && pend_v_q && !out_free;
  assign next_idx     = (idx_q == last_ptr) ? '0 : idx_q + PTR_W'(1);
  assign next_wp      = (wp_q == last_ptr) ? '0 : wp_q + PTR_W'(1);

  assign out_valid_o  = out_full_q;
  assign out_data_o   = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      otrb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            otrb_pkg::MODE_WRITE,
            otrb_pkg::MODE_CLEAR: state_d = otrb_pkg::ST_DONE;
            otrb_pkg::MODE_DUMP: begin
              if (held_q == '0 || in_data_i.max_count == '0) begin
                state_d = otrb_pkg::ST_DONE;
              end else begin
                state_d = otrb_pkg::ST_READ;
              end
            end
            otrb_pkg::MODE_QUERY: begin
              if (held_q == '0) begin
                state_d = otrb_pkg::ST_DONE;
              end else begin
                state_d = otrb_pkg::ST_READ;
              end
            end
            default: ;
          endcase
        end
      end
      otrb_pkg::ST_READ: state_d = otrb_pkg::ST_EVAL;
      otrb_pkg::ST_EVAL: begin
        if (!push_blocked) begin
          state_d = (last_visit || cap_hit) ? otrb_pkg::ST_DONE : otrb_pkg::ST_READ;
        end
      end
      otrb_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = otrb_pkg::ST_IDLE;
        end
      end
      default: state_d = otrb_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wp_d        = wp_q;
    held_d      = held_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    max_d       = max_q;
    thr_d       = thr_q;
    dump_d      = dump_q;
    pend_v_d    = pend_v_q;
    pend_lvl_d  = pend_lvl_q;
    pend_pay_d  = pend_pay_q;
    out_full_d  = out_full_q && !out_ready_i;
    out_d       = out_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q;
    ram_wdata_o = {LEVEL_BITS'(in_data_i.entry_level),
                   PAYLOAD_BITS'(in_data_i.entry_payload)};
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;

    unique case (state_q)
      otrb_pkg::ST_IDLE: begin
        if (cfg_i.clear) begin
          wp_d   = '0;
          held_d = '0;
        end
        if (accept) begin
          dump_d   = (in_mode == otrb_pkg::MODE_DUMP);
          thr_d    = (in_mode == otrb_pkg::MODE_DUMP) ? in_data_i.min_level
                                                      : cfg_i.err_level;
          max_d    = in_data_i.max_count;
          cnt_d    = '0;
          n_d      = '0;
          pend_v_d = 1'b0;
          idx_d    = (held_q < depth) ? '0 : wp_q;
          unique case (in_mode)
            otrb_pkg::MODE_WRITE: begin
              ram_we_o = 1'b1;
              wp_d     = next_wp;
              if (held_q < depth) begin
                held_d = held_q + CNT_W'(1);
              end
            end
            otrb_pkg::MODE_CLEAR: begin
              wp_d   = '0;
              held_d = '0;
            end
            default: ;
          endcase
        end
      end
      otrb_pkg::ST_READ: begin
        ram_re_o = 1'b1;
      end
      otrb_pkg::ST_EVAL: begin
        if (!push_blocked) begin
          if (match) begin
            if (dump_q && pend_v_q) begin
              out_full_d        = 1'b1;
              out_d.out_valid   = 1'b1;
              out_d.out_level   = pend_lvl_q;
              out_d.out_payload = pend_pay_q;
              out_d.last_of_run = 1'b0;
              out_d.stored_count = otrb_pkg::COUNT_W'(held_q);
            end
            pend_v_d   = 1'b1;
            pend_lvl_d = rd_lvl;
            pend_pay_d = otrb_pkg::PAYLOAD_W'(rd_pay);
            if (dump_q) begin
              n_d = n_q + otrb_pkg::COUNT_W'(1);
            end
          end
          cnt_d = cnt_q + CNT_W'(1);
          idx_d = next_idx;
        end
      end
      otrb_pkg::ST_DONE: begin
        if (out_free) begin
          out_full_d         = 1'b1;
          out_d.out_valid    = pend_v_q;
          out_d.out_level    = pend_v_q ? pend_lvl_q : '0;
          out_d.out_payload  = pend_v_q ? pend_pay_q : '0;
          out_d.last_of_run  = 1'b1;
          out_d.stored_count = otrb_pkg::COUNT_W'(held_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= otrb_pkg::ST_IDLE;
      wp_q       <= '0;
      held_q     <= '0;
      out_full_q <= 1'b0;
      pend_v_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      wp_q       <= wp_d;
      held_q     <= held_d;
      out_full_q <= out_full_d;
      pend_v_q   <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    cnt_q      <= cnt_d;
    n_q        <= n_d;
    max_q      <= max_d;
    thr_q      <= thr_d;
    dump_q     <= dump_d;
    pend_lvl_q <= pend_lvl_d;
    pend_pay_q <= pend_pay_d;
    out_q      <= out_d;
  end

endmodule

// ----- hw/rtl/overwrite_ring_trace_buffer.sv -----
// overwrite_ring_trace_buffer: top level of the overwriting ring trace store
// depends on otrb_pkg, otrb_cfg, otrb_ctrl, otrb_ram
//
//   channel   direction  signals                               payload
//   input     in         in_valid_i / in_ready_o               otrb_pkg::in_item_t
//   result    out        out_valid_o / out_ready_i             otrb_pkg::out_item_t
//   config    in/out     psel penable pwrite paddr pwdata ...  32-bit registers at 0 and 4
//
// a last-error query reads every stored entry and a dump at most as many, ending early
// once max_count entries have matched and at once when max_count is zero, with one ram
// read and one level compare per stored entry
// no clearing pass: the ring is usable straight out of reset
// a full output register stalls a dump's walk when a matched entry must be pushed out;
// the next transaction is taken once the final result sits in the output register

module overwrite_ring_trace_buffer #(
  parameter int unsigned DEPTH        = 64,
  parameter int unsigned PAYLOAD_BITS = 64,
  parameter int unsigned LEVEL_BITS   = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  otrb_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output otrb_pkg::out_item_t             out_data_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [otrb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [otrb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [otrb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned WIDTH  = LEVEL_BITS + PAYLOAD_BITS;

  otrb_pkg::cfg_t    cfg;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WIDTH-1:0]  ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WIDTH-1:0]  ram_rdata;

  otrb_cfg #(
    .DEPTH (DEPTH)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  otrb_ctrl #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .LEVEL_BITS   (LEVEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  otrb_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
